### rtl/core/mexp_pkg.sv
package mexp_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    typedef logic [WIDTH-1:0] t_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_TEST,
        S_MUL,
        S_SQR,
        S_OUT
    } t_state;

    // Request to the shared modular multiplier: result = x * y mod m.
    typedef struct packed {
        logic  start;
        t_word x;
        t_word y;
        t_word m;
    } t_mm_req;

    typedef struct packed {
        logic  busy;
        logic  done;
        t_word result;
    } t_mm_rsp;

    // (a + b) mod m for a, b < m and m nonzero.
    function automatic t_word add_mod(input t_word a, input t_word b, input t_word m);
        logic [WIDTH:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s >= {1'b0, m}) begin
                s = s - {1'b0, m};
            end
            return s[WIDTH-1:0];
        end
    endfunction

endpackage

### rtl/core/mexp_mulmod.sv
module mexp_mulmod
    import mexp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_mm_req i_req,
    output t_mm_rsp o_rsp
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    t_word            r_acc,  n_acc;
    t_word            r_x,    n_x;
    t_word            r_y,    n_y;
    t_word            r_m,    n_m;
    t_word            dbl;

    // One multiplier bit per cycle, most significant first: double, then add x.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        n_m    = r_m;
        dbl    = add_mod(r_acc, r_acc, r_m);
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(WIDTH - 1);
            n_acc  = '0;
            n_x    = i_req.x;
            n_y    = i_req.y;
            n_m    = i_req.m;
        end else if (r_busy) begin
            n_acc = r_y[WIDTH-1] ? add_mod(dbl, r_x, r_m) : dbl;
            n_y   = r_y << 1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
        r_m   <= n_m;
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

endmodule

### rtl/core/modular_exponentiation_unit.sv
// Modular exponentiation: o_power_mod = i_base ** i_exponent mod i_modulus.
// Input channel i_valid/o_ready carries base, exponent and modulus in one
// beat; output channel o_valid/i_ready returns power_mod and bad_modulus.
// One item at a time: o_ready is high only while the block is idle.
// A zero modulus returns 0 with o_bad_modulus set; o_valid rises the cycle
// after the input beat. Otherwise the base is first reduced (one modular
// product), then the exponent is scanned from its low bit: each bit up to
// the highest set one passes through a test state, a square and, for a set
// bit, a multiply, each product on the single shift-add-reduce multiplier
// (one bit per cycle). A zero exponent returns 1.
// The multiplier sets the rate; the next item is taken only once the result
// beat has been delivered and the block is idle again.
// The result is held in registers with o_valid high until i_ready takes it;
// a stalled receiver simply keeps the block in its output state.
// Synchronous active-low reset returns the block to idle and drops any item
// in flight.
module modular_exponentiation_unit
    import mexp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_word i_base,
    input  t_word i_exponent,
    input  t_word i_modulus,
    output logic  o_valid,
    input  logic  i_ready,
    output t_word o_power_mod,
    output logic  o_bad_modulus
);

    t_state  r_state, n_state;
    t_word   r_b,     n_b;
    t_word   r_e,     n_e;
    t_word   r_m,     n_m;
    t_word   r_res,   n_res;
    t_word   r_power, n_power;
    logic    r_bad,   n_bad;
    t_mm_req mm_req;
    t_mm_rsp mm_rsp;

    mexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .o_rsp   (mm_rsp)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                n_state = (i_modulus == '0) ? S_OUT : S_RED;
            end
            S_RED: if (mm_rsp.done) begin
                n_state = S_TEST;
            end
            S_TEST: begin
                if (r_e == '0) begin
                    n_state = S_OUT;
                end else if (r_e[0]) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_SQR;
                end
            end
            S_MUL: if (mm_rsp.done) begin
                n_state = S_SQR;
            end
            S_SQR: if (mm_rsp.done) begin
                n_state = S_TEST;
            end
            S_OUT: if (i_ready) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and multiplier requests.
    always_comb begin
        o_ready      = 1'b0;
        o_valid      = 1'b0;
        mm_req.start = 1'b0;
        mm_req.x     = r_b;
        mm_req.y     = r_b;
        mm_req.m     = r_m;
        unique case (r_state)
            S_IDLE: begin
                // Reduce the base: 1 * base mod m.
                o_ready      = 1'b1;
                mm_req.start = i_valid && (i_modulus != '0);
                mm_req.x     = WIDTH'(1);
                mm_req.y     = i_base;
                mm_req.m     = i_modulus;
            end
            S_TEST: begin
                mm_req.start = (r_e != '0);
                mm_req.x     = r_e[0] ? r_res : r_b;
            end
            S_MUL: begin
                mm_req.start = mm_rsp.done;
            end
            S_OUT: begin
                o_valid = 1'b1;
            end
            S_RED, S_SQR: begin
            end
            default: begin
            end
        endcase
    end

    // Datapath registers.
    always_comb begin
        n_b     = r_b;
        n_e     = r_e;
        n_m     = r_m;
        n_res   = r_res;
        n_power = r_power;
        n_bad   = r_bad;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                n_b     = i_base;
                n_e     = i_exponent;
                n_m     = i_modulus;
                n_res   = WIDTH'(1);
                n_power = '0;
                n_bad   = (i_modulus == '0);
            end
            S_RED: if (mm_rsp.done) begin
                n_b = mm_rsp.result;
            end
            S_TEST: if (r_e == '0) begin
                n_power = r_res;
            end
            S_MUL: if (mm_rsp.done) begin
                n_res = mm_rsp.result;
            end
            S_SQR: if (mm_rsp.done) begin
                n_b = mm_rsp.result;
                n_e = r_e >> 1;
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_b     <= n_b;
        r_e     <= n_e;
        r_m     <= n_m;
        r_res   <= n_res;
        r_power <= n_power;
        r_bad   <= n_bad;
    end

    assign o_power_mod   = r_power;
    assign o_bad_modulus = r_bad;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input and output handshakes open together");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_modulus |-> o_power_mod == '0)
        else $error("bad modulus with nonzero result");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_req.start |-> !mm_rsp.busy)
        else $error("multiplier started while busy");

    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_rsp.done |-> (r_state == S_RED || r_state == S_MUL || r_state == S_SQR))
        else $error("product finished with no state waiting for it");

endmodule

### bench/mexp_checker.sv
module mexp_checker
    import mexp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_ready,
    input  t_word i_base,
    input  t_word i_exponent,
    input  t_word i_modulus,
    input  logic  i_out_valid,
    input  logic  i_out_ready,
    input  t_word i_power_mod,
    input  logic  i_bad_modulus,
    output int    o_mismatches,
    output int    o_outstanding,
    output int    o_results,
    output int    o_zero_modulus
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_word power_mod;
        logic  bad_modulus;
    } t_power_result;

    t_power_result pending_powers[$];
    t_power_result oldest;
    int            mismatches = 0;
    int            results = 0;
    int            zero_modulus = 0;
    int            outstanding = 0;

    assign o_mismatches   = mismatches;
    assign o_outstanding  = outstanding;
    assign o_results      = results;
    assign o_zero_modulus = zero_modulus;

    // Square-and-multiply on double-width products, reduced after each step.
    function automatic t_power_result predict_power(input t_word b, input t_word e,
                                                    input t_word m);
        logic [2*WIDTH-1:0] acc;
        logic [2*WIDTH-1:0] sq;
        logic [2*WIDTH-1:0] mm;
        t_word              ebits;
        t_power_result      r;
        r.bad_modulus = 1'b0;
        r.power_mod   = '0;
        if (m == '0) begin
            r.bad_modulus = 1'b1;
            return r;
        end
        mm    = {{WIDTH{1'b0}}, m};
        sq    = {{WIDTH{1'b0}}, b} % mm;
        acc   = (2*WIDTH)'(1);
        ebits = e;
        // A zero exponent leaves acc at 1, even for a modulus of one.
        while (ebits != '0) begin
            if (ebits[0]) begin
                acc = (acc * sq) % mm;
            end
            sq    = (sq * sq) % mm;
            ebits = ebits >> 1;
        end
        r.power_mod = acc[WIDTH-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input t_word want_v,
                                   input t_word got_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%t mismatch on %s: expected %h, got %h", $realtime, field,
                     want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pending_powers.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                pending_powers.push_back(predict_power(i_base, i_exponent, i_modulus));
            end
            if (i_out_valid && i_out_ready) begin
                results++;
                if (pending_powers.size() == 0) begin
                    report_mismatch("unexpected result beat", '0, i_power_mod);
                end else begin
                    oldest = pending_powers.pop_front();
                    if (oldest.bad_modulus) begin
                        zero_modulus++;
                    end
                    if (i_power_mod !== oldest.power_mod) begin
                        report_mismatch("power_mod", oldest.power_mod, i_power_mod);
                    end
                    if (i_bad_modulus !== oldest.bad_modulus) begin
                        report_mismatch("bad_modulus", t_word'(oldest.bad_modulus),
                                        t_word'(i_bad_modulus));
                    end
                end
            end
        end
        outstanding = pending_powers.size();
    end

endmodule

### bench/modular_exponentiation_unit_tb.sv
module modular_exponentiation_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mexp_pkg::*;

    localparam int    WATCHDOG_LIMIT  = 20000;
    localparam int    HOLD_OFF_CYCLES = 3000;
    localparam int    SETTLE_CYCLES   = 100;
    localparam int    RANDOM_PER_MIX  = 87;
    localparam t_word ALL_ONES        = '1;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_ready = 1'b0;
    t_word i_base = '0;
    t_word i_exponent = '0;
    t_word i_modulus = '0;
    logic  o_ready;
    logic  o_valid;
    t_word o_power_mod;
    logic  o_bad_modulus;

    int mismatches;
    int outstanding;
    int results;
    int zero_modulus;

    int items_sent = 0;
    int directed_items = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    modular_exponentiation_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_base       (i_base),
        .i_exponent   (i_exponent),
        .i_modulus    (i_modulus),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_power_mod  (o_power_mod),
        .o_bad_modulus(o_bad_modulus)
    );

    mexp_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_base        (i_base),
        .i_exponent    (i_exponent),
        .i_modulus     (i_modulus),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_power_mod   (o_power_mod),
        .i_bad_modulus (o_bad_modulus),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_results     (results),
        .o_zero_modulus(zero_modulus)
    );

    always #6 i_clk = ~i_clk;

    // Receiver: random backpressure, or a long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_OFF_CYCLES;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: any beat on either channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Entered and left at a falling edge; valid stays up after the beat.
    task automatic send_item(input t_word b, input t_word e, input t_word m);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_base     <= b;
        i_exponent <= e;
        i_modulus  <= m;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random();
        t_word b;
        t_word e;
        t_word m;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            m = '0;
        end else if (pick < 9) begin
            m = 1;
        end else if (pick < 25) begin
            m = $urandom_range(255, 2);
        end else if (pick < 45) begin
            m = $urandom | {1'b1, {(WIDTH-1){1'b0}}};
        end else begin
            m = $urandom;
        end
        b = ($urandom_range(99) < 15) ? t_word'($urandom_range(3)) : t_word'($urandom);
        // Keep most exponents short; long ones dominate the latency.
        pick = $urandom_range(99);
        if (pick < 8) begin
            e = '0;
        end else if (pick < 70) begin
            e = $urandom & ~(ALL_ONES << $urandom_range(12, 1));
        end else if (pick < 90) begin
            e = $urandom & ~(ALL_ONES << $urandom_range(20, 13));
        end else begin
            e = $urandom;
        end
        send_item(b, e, m);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (outstanding != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Change the idle mix away from the falling edge that the receiver samples on.
    task automatic set_mix(input int send_pct, input int recv_pct, input bit hold);
        @(posedge i_clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        if (hold) begin
            hold_req = hold_req + 1;
        end
        @(negedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_mix(19, 83, 1'b0);
        send_item('0, '0, '0);
        send_item(ALL_ONES, ALL_ONES, '0);
        send_item(5, '0, 7);
        send_item('0, '0, 1);
        send_item(123, 5, 1);
        send_item(ALL_ONES, ALL_ONES, ALL_ONES);
        send_item(ALL_ONES, ALL_ONES, ALL_ONES - 1);
        send_item('0, 5, 13);
        send_item(2, 10, 1000);
        send_item(ALL_ONES, 1, 32'hFFFF_FFFB);
        send_item(3, ALL_ONES, ALL_ONES);
        send_item(32'h8000_0000, 2, ALL_ONES);
        send_item(1, ALL_ONES, 2);
        send_item(2, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(ALL_ONES, 32'h8000_0000, 32'h8000_0000);
        // Fermat: a^(p-1) mod p is 1 for the prime 2^32 - 5.
        send_item(32'hDEAD_BEEF, 32'hFFFF_FFFA, 32'hFFFF_FFFB);
        send_item(7, '0, ALL_ONES);
        send_item(1000, 3, 7);
        send_item(32'h0001_0001, 32'h0000_FFFF, 32'h0001_0003);
        directed_items = items_sent;

        repeat (RANDOM_PER_MIX) send_random();
        drain();

        set_mix(83, 19, 1'b0);
        repeat (RANDOM_PER_MIX / 2) send_random();
        drain();
        repeat (RANDOM_PER_MIX - RANDOM_PER_MIX / 2) send_random();
        drain();

        // Hold the result port while the sender keeps offering beats.
        set_mix(0, 0, 1'b1);
        repeat (RANDOM_PER_MIX) send_random();
        drain();

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Covered %0d items (%0d directed) under three idle mixes, drain pauses",
                 items_sent, directed_items);
        $display("and a %0d-cycle result stall; %0d results checked, %0d zero modulus, %0d bad.",
                 HOLD_OFF_CYCLES, results, zero_modulus, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
